[hw/rtl/assert_macros.svh]
// assertion macros used by the core top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge while out of reset
`define APDST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define APDST_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/apdst_pkg.sv]
// types and constants of the axle passage distance statistics block
`default_nettype none

package apdst_pkg;

	localparam int MAX_AXLES = 256;
	localparam int ADDR_W    = $clog2(MAX_AXLES);
	localparam int CNT_W     = $clog2(MAX_AXLES + 1);

	localparam int ID_W    = 8;
	localparam int SPEED_W = 16;
	localparam int GAP_W   = 32;
	localparam int STEP_W  = 49;
	localparam int TOTAL_W = 56;
	localparam int POS_W   = 9;
	localparam int STAT_W  = 16;
	localparam int FAULT_W = 3;

	localparam int SSUM_W = SPEED_W + ADDR_W;
	localparam int NV_W   = CNT_W + SPEED_W;
	localparam int ACC_W  = NV_W + CNT_W;
	localparam int DIVS_W = 2 * CNT_W;

	localparam int IN_W  = 56;
	localparam int OUT_W = 152;

	localparam logic KIND_AXLE    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [FAULT_W-1:0] {
		FAULT_NONE,
		FAULT_ID,
		FAULT_FIRST_GAP,
		FAULT_FEW_AXLES,
		FAULT_FULL
	} fault_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULT,
		ST_UPDATE,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_SCAN_RD,
		ST_SCAN_MUL,
		ST_SCAN_ACC,
		ST_DEV_GO,
		ST_DEV_WAIT,
		ST_SUMMARY
	} state_t;

	typedef struct packed {
		logic capture;
		logic do_mult;
		logic do_update;
		logic mean_start;
		logic mean_store;
		logic dev_start;
		logic scan_rd;
		logic scan_mul;
		logic scan_acc;
		logic do_summary;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic div_done;
		logic scan_done;
		logic last_item;
	} sts_t;

endpackage

`default_nettype wire

[hw/rtl/apdst_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none

module apdst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/apdst_div.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none

module apdst_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [apdst_pkg::ACC_W-1:0]   dividend,
	input  wire logic [apdst_pkg::DIVS_W-1:0]  divisor,
	output logic                               done,
	output logic      [apdst_pkg::ACC_W-1:0]   quotient
);

	import apdst_pkg::*;

	localparam int ITER_W = $clog2(ACC_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] iter_q;
	logic [DIVS_W-1:0] rem_q;
	logic [ACC_W-1:0]  quo_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [DIVS_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[ACC_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= busy_q && (iter_q == ITER_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(ACC_W);
			end else if (busy_q) begin
				iter_q <= iter_q - ITER_W'(1);
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// dividend shifts out at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DIVS_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[DIVS_W-1:0];
			end
			quo_q <= {quo_q[ACC_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

[hw/rtl/apdst_ctrl.sv]
// sequencer for per-axle updates and the end-of-train summary pass
`default_nettype none

module apdst_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire apdst_pkg::sts_t   sts,
	output apdst_pkg::cmd_t        cmd
);

	import apdst_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_MULT;
				end
			end
			ST_MULT: begin
				cmd.do_mult = 1'b1;
				state_d     = ST_UPDATE;
			end
			ST_UPDATE: begin
				// hold until the output register can take the beat
				if (sts.out_free) begin
					cmd.do_update = 1'b1;
					state_d       = sts.last_item ? ST_MEAN_GO : ST_IDLE;
				end
			end
			ST_MEAN_GO: begin
				cmd.mean_start = 1'b1;
				state_d        = ST_MEAN_WAIT;
			end
			ST_MEAN_WAIT: begin
				if (sts.div_done) begin
					cmd.mean_store = 1'b1;
					state_d        = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = ST_SCAN_MUL;
			end
			ST_SCAN_MUL: begin
				cmd.scan_mul = 1'b1;
				state_d      = ST_SCAN_ACC;
			end
			ST_SCAN_ACC: begin
				cmd.scan_acc = 1'b1;
				state_d      = sts.scan_done ? ST_DEV_GO : ST_SCAN_RD;
			end
			ST_DEV_GO: begin
				cmd.dev_start = 1'b1;
				state_d       = ST_DEV_WAIT;
			end
			ST_DEV_WAIT: begin
				if (sts.div_done) begin
					state_d = ST_SUMMARY;
				end
			end
			ST_SUMMARY: begin
				if (sts.out_free) begin
					cmd.do_summary = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/apdst_dp.sv]
// datapath: train state, speed store, scan accumulator, divider and output register
`default_nettype none

module apdst_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire apdst_pkg::cmd_t              cmd,
	output apdst_pkg::sts_t                   sts,
	input  wire logic [apdst_pkg::IN_W-1:0]   in_data,
	input  wire logic                         in_last,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [apdst_pkg::OUT_W-1:0]  out_data,
	output logic                              out_kind,
	output logic                              out_end
);

	import apdst_pkg::*;

	// captured beat
	logic [ID_W-1:0]    id_q;
	logic [SPEED_W-1:0] speed_q;
	logic [GAP_W-1:0]   gap_q;
	logic               last_q;
	logic [STEP_W-1:0]  prod_q;

	// train state
	logic [SPEED_W-1:0] prev_speed_q;
	logic [ID_W-1:0]    prev_id_q;
	logic [CNT_W-1:0]   count_q;
	logic [TOTAL_W-1:0] dist_q;
	logic [SSUM_W-1:0]  ssum_q;

	// summary pass
	logic [ADDR_W-1:0]  idx_q;
	logic [NV_W-1:0]    nv_q;
	logic [ACC_W-1:0]   acc_q;
	logic [STAT_W-1:0]  mean_q;

	// output register
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;
	logic               out_kind_q;
	logic               out_end_q;

	logic [SPEED_W:0]   spd_pair;
	logic               full;
	logic               first;
	logic               gap_inf;
	logic [STEP_W-1:0]  step_d;
	logic [TOTAL_W:0]   tot_sum;
	logic [TOTAL_W-1:0] dist_next;
	logic [TOTAL_W-1:0] total_d;
	logic [CNT_W-1:0]   count_next;
	fault_t             fault_d;
	fault_t             sum_fault;
	logic [NV_W-1:0]    ssum_ext;
	logic [NV_W-1:0]    diff;
	logic [SPEED_W-1:0] rdata;
	logic               cnt_nz;
	logic               div_start;
	logic [ACC_W-1:0]   div_dvd;
	logic [DIVS_W-1:0]  div_dvs;
	logic               div_done;
	logic [ACC_W-1:0]   div_quo;
	logic [STAT_W-1:0]  dev_d;

	assign spd_pair = {1'b0, prev_speed_q} + {1'b0, speed_q};
	assign full     = count_q >= CNT_W'(MAX_AXLES);
	assign first    = count_q == '0;
	assign gap_inf  = gap_q == '1;

	always_comb begin
		if (full || first) begin
			step_d = '0;
		end else if (gap_inf) begin
			step_d = '1;
		end else begin
			step_d = prod_q;
		end
	end

	// saturating running total
	assign tot_sum   = {1'b0, dist_q} + (TOTAL_W + 1)'(step_d);
	assign dist_next = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
	assign total_d   = (full || first) ? dist_q : dist_next;
	assign count_next = full ? count_q : count_q + CNT_W'(1);

	always_comb begin
		if (full) begin
			fault_d = FAULT_FULL;
		end else if (first) begin
			fault_d = gap_inf ? FAULT_NONE : FAULT_FIRST_GAP;
		end else if (id_q != prev_id_q + ID_W'(1)) begin
			fault_d = FAULT_ID;
		end else begin
			fault_d = FAULT_NONE;
		end
	end

	assign sum_fault = (count_q < CNT_W'(2)) ? FAULT_FEW_AXLES : FAULT_NONE;
	assign cnt_nz    = count_q != '0;
	assign dev_d     = cnt_nz ? div_quo[STAT_W-1:0] : '0;

	assign ssum_ext = NV_W'(ssum_q);
	assign diff     = (nv_q >= ssum_ext) ? nv_q - ssum_ext : ssum_ext - nv_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			id_q    <= in_data[ID_W-1:0];
			speed_q <= in_data[ID_W +: SPEED_W];
			gap_q   <= in_data[ID_W + SPEED_W +: GAP_W];
			last_q  <= in_last;
		end
		if (cmd.do_mult) begin
			prod_q <= STEP_W'(spd_pair) * STEP_W'(gap_q);
		end
		if (cmd.mean_start) begin
			idx_q <= '0;
			acc_q <= '0;
		end else if (cmd.scan_acc) begin
			idx_q <= idx_q + ADDR_W'(1);
			acc_q <= acc_q + ACC_W'(diff);
		end
		if (cmd.scan_mul) begin
			nv_q <= NV_W'(count_q) * NV_W'(rdata);
		end
		if (cmd.mean_store) begin
			mean_q <= cnt_nz ? div_quo[STAT_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_speed_q <= '0;
			prev_id_q    <= '0;
			count_q      <= '0;
			dist_q       <= '0;
			ssum_q       <= '0;
		end else if (cmd.do_summary) begin
			prev_speed_q <= '0;
			prev_id_q    <= '0;
			count_q      <= '0;
			dist_q       <= '0;
			ssum_q       <= '0;
		end else if (cmd.do_update && !full) begin
			prev_speed_q <= speed_q;
			prev_id_q    <= id_q;
			count_q      <= count_next;
			dist_q       <= total_d;
			ssum_q       <= ssum_q + SSUM_W'(speed_q);
		end
	end

	apdst_ram #(
		.WIDTH (SPEED_W),
		.DEPTH (MAX_AXLES)
	) u_store (
		.clk   (clk),
		.we    (cmd.do_update && !full),
		.waddr (ADDR_W'(count_q)),
		.wdata (speed_q),
		.re    (cmd.scan_rd),
		.raddr (idx_q),
		.rdata (rdata)
	);

	assign div_start = cmd.mean_start || cmd.dev_start;
	assign div_dvd   = cmd.dev_start ? acc_q : ACC_W'(ssum_q);
	assign div_dvs   = cmd.dev_start ? DIVS_W'(count_q) * DIVS_W'(count_q) : DIVS_W'(count_q);

	apdst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.do_update || cmd.do_summary) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// tdata: position, step, total, mean, deviation, fault, zero pad
	always_ff @(posedge clk) begin
		if (cmd.do_update) begin
			out_kind_q <= KIND_AXLE;
			out_end_q  <= !last_q;
			out_data_q <= {3'b000, fault_d, STAT_W'(0), STAT_W'(0), total_d, step_d,
				POS_W'(count_next)};
		end else if (cmd.do_summary) begin
			out_kind_q <= KIND_SUMMARY;
			out_end_q  <= 1'b1;
			out_data_q <= {3'b000, sum_fault, dev_d, mean_q, dist_q, STEP_W'(0),
				POS_W'(count_q)};
		end
	end

	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.div_done  = div_done;
	assign sts.scan_done = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign sts.last_item = last_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_kind  = out_kind_q;
	assign out_end   = out_end_q;

endmodule

`default_nettype wire

[hw/rtl/axle_passage_distance_stats_core.sv]
// top level of the axle passage distance statistics block
//
//  port group  dir  tdata (lsb up)                                      tuser / tlast
//  s_axis      in   axle_number 8, speed 16, gap_time 32               - / final_axle
//  m_axis      out  axle_position 9, step_distance 49, total_distance  result_kind /
//                   56, mean_speed 16, mean_deviation 16, fault 3, pad  run_end
//
// an axle beat steps through capture, the 17 x 32 multiply, then the saturating add and
// state update; its result is loaded into the output register in the update step, and
// the next beat is taken once the block is back in idle
// a final axle then runs two serial divisions (start, 34 quotient bits, done), the mean
// before and the deviation after a walk of the speed store (ram read, multiply,
// accumulate per entry), and then loads the summary
// reset clears all control and train state at once; the store needs no clearing pass
// a result not yet taken holds the block in its update or summary step, and the next beat
// with it
`default_nettype none

`include "assert_macros.svh"

module axle_passage_distance_stats_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [apdst_pkg::IN_W-1:0]   s_axis_tdata,   // axle_number, speed, gap_time
	input  wire logic                         s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic      [apdst_pkg::OUT_W-1:0]  m_axis_tdata,   // position, step, total, mean,
	                                                           // deviation, fault
	output logic                              m_axis_tuser,   // result_kind
	output logic                              m_axis_tlast
);

	import apdst_pkg::*;

	cmd_t       cmd;
	sts_t       sts;
	logic [3:0] strobes;
	logic       summary_beat;

	apdst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	apdst_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_kind  (m_axis_tuser),
		.out_end   (m_axis_tlast)
	);

	assign strobes      = {cmd.capture, cmd.do_update, cmd.scan_acc, cmd.do_summary};
	assign summary_beat = m_axis_tvalid && (m_axis_tuser == KIND_SUMMARY);

	`APDST_ASSERT(a_busy_after_capture, cmd.capture |=> !s_axis_tready, "beat taken while busy")
	`APDST_ASSERT_ALWAYS(a_one_strobe, $onehot0(strobes), "conflicting datapath commands")
	`APDST_ASSERT(a_load_shows, (cmd.do_update || cmd.do_summary) |=> m_axis_tvalid, "result lost")
	`APDST_ASSERT(a_summary_ends, summary_beat |-> m_axis_tlast, "summary not last")

endmodule

`default_nettype wire

[test/tb.sv]
// testbench for the axle passage distance statistics core: stream stimulus, predictor, checks
`timescale 1ns / 1ps

module tb;
	import apdst_pkg::*;

	localparam int STEP_LO  = POS_W;
	localparam int TOTAL_LO = STEP_LO + STEP_W;
	localparam int MEAN_LO  = TOTAL_LO + TOTAL_W;
	localparam int DEV_LO   = MEAN_LO + STAT_W;
	localparam int FAULT_LO = DEV_LO + STAT_W;

	localparam logic [GAP_W-1:0] GAP_INF = '1;
	localparam longint unsigned STEP_ONES = (64'd1 << STEP_W) - 64'd1;
	localparam longint unsigned TOTAL_TOP = (64'd1 << TOTAL_W) - 64'd1;

	localparam int ITEM_GOAL   = 1450;
	localparam int STALL_LIMIT = 20000;
	localparam int LONG_HOLD   = 400;

	typedef struct {
		logic                kind;
		logic [POS_W-1:0]    pos;
		logic [STEP_W-1:0]   step;
		logic [TOTAL_W-1:0]  total;
		logic [STAT_W-1:0]   mean;
		logic [STAT_W-1:0]   dev;
		fault_t              fault;
		logic                run_end;
	} train_result_t;

	// tracks one train at a time and holds the results still owed by the block
	class train_ledger;
		logic [SPEED_W-1:0] last_speed = '0;
		logic [ID_W-1:0]    last_axle = '0;
		int                 axles = 0;
		longint unsigned    distance = 0;
		longint unsigned    speed_total = 0;
		logic [SPEED_W-1:0] speeds [MAX_AXLES];
		train_result_t      due_results [$];
		int                 fails = 0;

		task report(string what, longint unsigned got, longint unsigned want);
			$display("tb: mismatch %s got %0h want %0h", what, got, want);
			fails++;
		endtask

		function int pending();
			return due_results.size();
		endfunction

		function void note_passage(logic [ID_W-1:0] id, logic [SPEED_W-1:0] spd,
			logic [GAP_W-1:0] gap, logic fin);
			train_result_t r;
			longint unsigned step;
			longint unsigned sum;
			longint unsigned n;
			longint unsigned nv;
			longint unsigned acc;

			step = 0;
			r.fault = FAULT_NONE;
			if (axles >= MAX_AXLES) begin
				r.fault = FAULT_FULL;
			end else begin
				if (axles == 0) begin
					if (gap != GAP_INF)
						r.fault = FAULT_FIRST_GAP;
				end else begin
					if (id != last_axle + 8'd1)
						r.fault = FAULT_ID;
					if (gap == GAP_INF)
						step = STEP_ONES;
					else
						step = (longint'(last_speed) + longint'(spd)) * longint'(gap);
					sum = distance + step;
					distance = (sum > TOTAL_TOP) ? TOTAL_TOP : sum;
				end
				speeds[axles] = spd;
				axles++;
				speed_total += spd;
				last_speed = spd;
				last_axle = id;
			end
			r.kind = KIND_AXLE;
			r.pos = POS_W'(axles);
			r.step = STEP_W'(step);
			r.total = TOTAL_W'(distance);
			r.mean = '0;
			r.dev = '0;
			r.run_end = !fin;
			due_results.insert(due_results.size(), r);
			if (!fin)
				return;

			// train summary, then back to an empty train
			r.kind = KIND_SUMMARY;
			r.step = '0;
			r.mean = '0;
			r.dev = '0;
			r.fault = (axles < 2) ? FAULT_FEW_AXLES : FAULT_NONE;
			r.run_end = 1'b1;
			if (axles > 0) begin
				n = axles;
				acc = 0;
				for (int i = 0; i < axles; i++) begin
					nv = n * speeds[i];
					acc += (nv >= speed_total) ? nv - speed_total : speed_total - nv;
				end
				r.mean = STAT_W'(speed_total / n);
				r.dev = STAT_W'(acc / (n * n));
			end
			due_results.insert(due_results.size(), r);
			last_speed = '0;
			last_axle = '0;
			axles = 0;
			distance = 0;
			speed_total = 0;
		endfunction

		task check_result(logic [OUT_W-1:0] d, logic kind, logic fin);
			train_result_t want;

			if (due_results.size() == 0) begin
				report("unexpected result at position", d[POS_W-1:0], 0);
				return;
			end
			want = due_results.pop_front();
			if (kind !== want.kind)
				report("result_kind", kind, want.kind);
			if (d[POS_W-1:0] !== want.pos)
				report("axle_position", d[POS_W-1:0], want.pos);
			if (d[STEP_LO +: STEP_W] !== want.step)
				report("step_distance", d[STEP_LO +: STEP_W], want.step);
			if (d[TOTAL_LO +: TOTAL_W] !== want.total)
				report("total_distance", d[TOTAL_LO +: TOTAL_W], want.total);
			if (d[MEAN_LO +: STAT_W] !== want.mean)
				report("mean_speed", d[MEAN_LO +: STAT_W], want.mean);
			if (d[DEV_LO +: STAT_W] !== want.dev)
				report("mean_deviation", d[DEV_LO +: STAT_W], want.dev);
			if (d[FAULT_LO +: FAULT_W] !== want.fault)
				report("fault", d[FAULT_LO +: FAULT_W], want.fault);
			if (fin !== want.run_end)
				report("run_end", fin, want.run_end);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;   // axle_number, speed, gap_time
	logic s_axis_tlast = 1'b0;            // final_axle
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;       // position, step, total, mean, deviation, fault
	logic m_axis_tuser;                   // result_kind
	logic m_axis_tlast;                   // run_end

	train_ledger ledger;
	int sent_axles = 0;
	int hold_request = 0;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int quiet_cycles = 0;

	axle_passage_distance_stats_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			ledger.note_passage(s_axis_tdata[ID_W-1:0], s_axis_tdata[ID_W +: SPEED_W],
				s_axis_tdata[ID_W + SPEED_W +: GAP_W], s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			ledger.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// watchdog on beats in either direction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// result side: random stalls, and a long hold-off when asked
	initial begin
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end else begin
				stall = rx_idle ? $urandom_range(0, 13) : 0;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task send_axle(logic [ID_W-1:0] id, logic [SPEED_W-1:0] spd, logic [GAP_W-1:0] gap,
		logic fin);
		int pause;
		pause = tx_idle ? $urandom_range(0, 13) : 0;
		if (pause > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {gap, spd, id};
		s_axis_tlast <= fin;
		do @(posedge clk); while (!s_axis_tready);
		sent_axles++;
	endtask

	// stop offering and wait until every owed result has been taken
	task wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (ledger.pending() != 0);
	endtask

	function logic [GAP_W-1:0] pick_gap();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 2000);
			2: return '0;
			3: return GAP_INF - 1;
			default: return $urandom_range(1000, 200000);
		endcase
	endfunction

	function logic [SPEED_W-1:0] pick_speed();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return SPEED_W'($urandom);
			default: return SPEED_W'($urandom_range(500, 4000));
		endcase
	endfunction

	// one train; inf_pct is the share of infinite gaps after the first axle
	task run_train(int len, int inf_pct);
		logic [ID_W-1:0] id;
		logic [GAP_W-1:0] gap;
		id = ID_W'($urandom);
		for (int i = 0; i < len; i++) begin
			if (i > 0)
				id = ($urandom_range(0, 99) < 4) ? ID_W'($urandom) : id + 8'd1;
			if (i == 0)
				gap = ($urandom_range(0, 99) < 90) ? GAP_INF : pick_gap();
			else
				gap = ($urandom_range(0, 99) < inf_pct) ? GAP_INF : pick_gap();
			send_axle(id, pick_speed(), gap, i == len - 1);
		end
	endtask

	initial begin
		int trains;
		int len;
		ledger = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone axle, fine and with a finite first gap
		send_axle(8'd17, 16'd1234, GAP_INF, 1'b1);
		send_axle(8'd0, 16'hFFFF, 32'd0, 1'b1);
		// id wraps past 255, then a wrong id, then an infinite gap mid-train
		send_axle(8'd255, 16'd0, GAP_INF, 1'b0);
		send_axle(8'd0, 16'hFFFF, GAP_INF - 1, 1'b0);
		send_axle(8'd5, 16'hFFFF, GAP_INF - 1, 1'b0);
		send_axle(8'd6, 16'd100, GAP_INF, 1'b0);
		send_axle(8'd7, 16'd0, 32'd0, 1'b1);
		// fastest axles with the longest finite gap
		send_axle(8'hAA, 16'hFFFF, GAP_INF, 1'b0);
		send_axle(8'hAB, 16'hFFFF, GAP_INF - 1, 1'b0);
		send_axle(8'hAC, 16'hFFFF, GAP_INF - 1, 1'b1);
		// first gap not infinite inside a longer train
		send_axle(8'h55, 16'd3000, 32'h8000_0000, 1'b0);
		send_axle(8'h56, 16'd2990, 32'd5000, 1'b1);
		wait_drained();

		trains = 0;
		while (sent_axles < ITEM_GOAL) begin
			trains++;
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			if (trains == 10 || trains % 25 == 0)
				wait_drained();
			if (trains == 5) begin
				// hold results back while axles keep coming
				tx_idle = 1'b0;
				hold_request = LONG_HOLD;
			end
			if (trains == 2) begin
				// overfills the store and drives the total into saturation
				run_train(260, 65);
			end else if ($urandom_range(0, 59) == 0) begin
				run_train($urandom_range(250, 258), 30);
			end else begin
				len = $urandom_range(1, 12);
				run_train(len, 10);
			end
		end

		wait_drained();
		repeat (50) @(posedge clk);
		if (ledger.pending() != 0)
			ledger.report("results missing", ledger.pending(), 0);
		if (ledger.fails == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/apdst_pkg.sv
hw/rtl/apdst_ram.sv
hw/rtl/apdst_div.sv
hw/rtl/apdst_ctrl.sv
hw/rtl/apdst_dp.sv
hw/rtl/axle_passage_distance_stats_core.sv
test/tb.sv
